// ===== rtl/tun_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_pkg
// Shared types for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
package tun_pkg;

   localparam int CB = 16;
   localparam int FB = 14;
   localparam int EB = CB + 1;
   localparam int CPB = 2 * EB + 1;
   localparam int MAGB = CPB - 1;
   localparam int SB = 2 * MAGB + 2;
   localparam int RB = MAGB + 1;
   localparam int NB = FB + 2;
   localparam int QB = FB + 2;
   localparam int DB = MAGB + FB;

   typedef struct packed {
      logic [MAGB-1:0] ax;
      logic [MAGB-1:0] ay;
      logic [MAGB-1:0] az;
      logic            sx;
      logic            sy;
      logic            sz;
   } cross_type;

endpackage
`default_nettype wire

// ===== rtl/tun_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_sqrt_cell
// One bit of a restoring square root: tries the next root bit, passes on.
// ----------------------------------------------------------------------------
module tun_sqrt_cell
   import tun_pkg::*;
#(
   parameter int BIT = 0
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [SB-1:0]    s_i,
   input  wire logic [RB-1:0]    r_i,
   input  wire logic [SB-1:0]    r2_i,   // square of r_i
   input  wire cross_type        c_i,
   output      logic [SB-1:0]    s_o,
   output      logic [RB-1:0]    r_o,
   output      logic [SB-1:0]    r2_o,
   output      cross_type        c_o
);
   logic [RB-1:0]   t;
   logic [SB-1:0]   sq;
   logic [SB-1:0]   s_ff;
   logic [RB-1:0]   r_ff;
   logic [SB-1:0]   r2_ff;
   cross_type       c_ff;

   always_comb begin
      t  = r_i | (RB'(1) << BIT);
      sq = r2_i + (SB'(r_i) << (BIT + 1)) + (SB'(1) << (2 * BIT));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff  <= s_i;
         c_ff  <= c_i;
         r_ff  <= (sq <= s_i) ? t : r_i;
         r2_ff <= (sq <= s_i) ? sq : r2_i;
      end
   end

   assign s_o = s_ff;
   assign r_o = r_ff;
   assign r2_o = r2_ff;
   assign c_o = c_ff;
endmodule
`default_nettype wire

// ===== rtl/tun_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tun_div_cell
// One quotient bit of three restoring divisions sharing the divisor.
// ----------------------------------------------------------------------------
module tun_div_cell
   import tun_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic [RB-1:0]    d_i,
   input  wire logic [3*DB-1:0]  n_i,
   input  wire logic [3*QB-1:0]  q_i,
   input  wire logic [3*RB-1:0]  rem_i,
   input  wire logic [2:0]       sg_i,
   output      logic [RB-1:0]    d_o,
   output      logic [3*DB-1:0]  n_o,
   output      logic [3*QB-1:0]  q_o,
   output      logic [3*RB-1:0]  rem_o,
   output      logic [2:0]       sg_o
);
   logic [RB:0]      sh [3];
   logic [3*QB-1:0]  q_in;
   logic [3*RB-1:0]  rem_in;
   logic [3*DB-1:0]  n_in;
   logic [RB-1:0]    d_ff;
   logic [3*DB-1:0]  n_ff;
   logic [3*QB-1:0]  q_ff;
   logic [3*RB-1:0]  rem_ff;
   logic [2:0]       sg_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sh[k] = {rem_i[k*RB +: RB], n_i[k*DB + DB-1]};
         n_in[k*DB +: DB] = {n_i[k*DB +: DB-1], 1'b0};
         if (sh[k] >= {1'b0, d_i}) begin
            rem_in[k*RB +: RB] = RB'(sh[k] - {1'b0, d_i});
            q_in[k*QB +: QB]   = {q_i[k*QB +: QB-1], 1'b1};
         end else begin
            rem_in[k*RB +: RB] = RB'(sh[k]);
            q_in[k*QB +: QB]   = {q_i[k*QB +: QB-1], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff   <= d_i;
         n_ff   <= n_in;
         q_ff   <= q_in;
         rem_ff <= rem_in;
         sg_ff  <= sg_i;
      end
   end

   assign d_o = d_ff;
   assign n_o = n_ff;
   assign q_o = q_ff;
   assign rem_o = rem_ff;
   assign sg_o = sg_ff;
endmodule
`default_nettype wire

// ===== rtl/triangle_unit_normal.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Pipelined unit normal of a triangle: cross product, root, three divides.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit first)
// req     | in  | first_x/y/z, second_x/y/z, third_x/y/z, 16 b each
// rsp     | out | normal_x/y/z 16 b each, degenerate 1 b, pad
// One request per cycle while the output is not stalled; 4 front stages,
// 35 root cells (one per root bit), 48 divide cells (one per dividend bit).
// Whole chain advances when the output stage is free or taken.
// Reset clears valid bits only.
// ----------------------------------------------------------------------------
module triangle_unit_normal
   import tun_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   input  wire logic [143:0]  req_tdata,  // first_x,y,z, second_x,y,z, third_x,y,z
   output      logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   output      logic [55:0]   rsp_tdata   // normal_x, normal_y, normal_z, degenerate
);
   localparam int DEPTH = 4 + RB + DB;

   logic [DEPTH-1:0] vld_ff, vld_in;
   logic en;

   assign en = !vld_ff[DEPTH-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[DEPTH-1];
   assign vld_in = {vld_ff[DEPTH-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // edges
   logic signed [EB-1:0] e1_ff [3], e2_ff [3];
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            e1_ff[k] <= EB'($signed(req_tdata[(3+k)*CB +: CB]))
                      - EB'($signed(req_tdata[k*CB +: CB]));
            e2_ff[k] <= EB'($signed(req_tdata[(6+k)*CB +: CB]))
                      - EB'($signed(req_tdata[k*CB +: CB]));
         end
      end
   end

   // products
   logic signed [2*EB-1:0] p_ff [6];
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= e1_ff[1] * e2_ff[2];
         p_ff[1] <= e1_ff[2] * e2_ff[1];
         p_ff[2] <= e1_ff[2] * e2_ff[0];
         p_ff[3] <= e1_ff[0] * e2_ff[2];
         p_ff[4] <= e1_ff[0] * e2_ff[1];
         p_ff[5] <= e1_ff[1] * e2_ff[0];
      end
   end

   // cross product as magnitude and sign
   logic signed [CPB-1:0] c [3];
   cross_type cr_ff;
   always_comb begin
      for (int k = 0; k < 3; k++)
         c[k] = CPB'(p_ff[2*k]) - CPB'(p_ff[2*k+1]);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         cr_ff.ax <= MAGB'(c[0][CPB-1] ? -c[0] : c[0]);
         cr_ff.ay <= MAGB'(c[1][CPB-1] ? -c[1] : c[1]);
         cr_ff.az <= MAGB'(c[2][CPB-1] ? -c[2] : c[2]);
         cr_ff.sx <= c[0][CPB-1];
         cr_ff.sy <= c[1][CPB-1];
         cr_ff.sz <= c[2][CPB-1];
      end
   end

   // sum of squares
   logic [SB-1:0] s_ff;
   logic [2*MAGB-1:0] sqx, sqy, sqz;
   cross_type cs_ff;
   always_comb begin
      sqx = cr_ff.ax * cr_ff.ax;
      sqy = cr_ff.ay * cr_ff.ay;
      sqz = cr_ff.az * cr_ff.az;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= SB'(sqx) + SB'(sqy) + SB'(sqz);
         cs_ff <= cr_ff;
      end
   end

   // root chain
   logic [SB-1:0] sq_s [RB+1];
   logic [RB-1:0] sq_r [RB+1];
   logic [SB-1:0] sq_r2 [RB+1];
   cross_type     sq_c [RB+1];
   assign sq_s[0] = s_ff;
   assign sq_r[0] = '0;
   assign sq_r2[0] = '0;
   assign sq_c[0] = cs_ff;
   for (genvar g = 0; g < RB; g++) begin : g_sqrt
      tun_sqrt_cell #(.BIT(RB-1-g)) u_cell (
         .clock(clock), .en(en),
         .s_i(sq_s[g]), .r_i(sq_r[g]), .r2_i(sq_r2[g]), .c_i(sq_c[g]),
         .s_o(sq_s[g+1]), .r_o(sq_r[g+1]), .r2_o(sq_r2[g+1]), .c_o(sq_c[g+1]));
   end

   // divide chain
   cross_type cf;
   assign cf = sq_c[RB];
   logic [RB-1:0]   dv_d [DB+1];
   logic [3*DB-1:0] dv_n [DB+1];
   logic [3*QB-1:0] dv_q [DB+1];
   logic [3*RB-1:0] dv_r [DB+1];
   logic [2:0]      dv_s [DB+1];
   assign dv_d[0] = sq_r[RB];
   assign dv_n[0] = {{cf.az, FB'(0)}, {cf.ay, FB'(0)}, {cf.ax, FB'(0)}};
   assign dv_q[0] = '0;
   assign dv_r[0] = '0;
   assign dv_s[0] = {cf.sz, cf.sy, cf.sx};
   for (genvar g = 0; g < DB; g++) begin : g_div
      tun_div_cell u_cell (
         .clock(clock), .en(en),
         .d_i(dv_d[g]), .n_i(dv_n[g]), .q_i(dv_q[g]), .rem_i(dv_r[g]), .sg_i(dv_s[g]),
         .d_o(dv_d[g+1]), .n_o(dv_n[g+1]), .q_o(dv_q[g+1]), .rem_o(dv_r[g+1]),
         .sg_o(dv_s[g+1]));
   end

   logic dgn;
   logic [NB-1:0] nv [3];
   assign dgn = (dv_d[DB] == '0);
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dgn)
            nv[k] = '0;
         else if (dv_s[DB][k])
            nv[k] = NB'(-dv_q[DB][k*QB +: QB]);
         else
            nv[k] = NB'(dv_q[DB][k*QB +: QB]);
      end
   end
   assign rsp_tdata = {7'd0, dgn, nv[2], nv[1], nv[0]};

`ifndef SYNTHESIS
   a_dgn_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[48] |-> rsp_tdata[47:0] == '0) else $error("degenerate nonzero");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("output moved");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready) else $error("stalled while empty");
`endif
endmodule
`default_nettype wire

// ===== sim/triangle_unit_normal_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_unit_normal_tb
// Streams triangles through the unit normal pipeline and compares every
// normal and degenerate flag against a behavioral cross product, integer
// root and truncating divide, under random idling and a long output stall.
// ----------------------------------------------------------------------------
module triangle_unit_normal_tb;
   import tun_pkg::*;

   typedef struct packed {
      logic               degen;
      logic signed [15:0] nz;
      logic signed [15:0] ny;
      logic signed [15:0] nx;
   } normal_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   logic [143:0]  req_tdata;   // first_x,y,z, second_x,y,z, third_x,y,z
   logic          rsp_tvalid;
   logic          rsp_tready;
   logic [55:0]   rsp_tdata;   // normal_x, normal_y, normal_z, degenerate, pad

   normal_type normal_q[$];
   int         error_count = 0;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         hold_cycles = 0;

   triangle_unit_normal u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic [63:0] int_sqrt(logic [127:0] s);
      logic [63:0]  r;
      logic [63:0]  t;
      logic [127:0] sq;
      r = '0;
      for (int b = 56; b >= 0; b--) begin
         t = r | (64'd1 << b);
         sq = 128'(t) * 128'(t);
         if (sq <= s) r = t;
      end
      return r;
   endfunction

   function automatic normal_type unit_normal(logic [143:0] tri_bits);
      longint    v[9];
      longint    e1[3], e2[3], c[3];
      logic [127:0] s;
      logic [63:0]  m;
      longint    q;
      normal_type n;
      for (int i = 0; i < 9; i++) v[i] = longint'($signed(tri_bits[16*i +: 16]));
      for (int i = 0; i < 3; i++) begin
         e1[i] = v[3+i] - v[i];
         e2[i] = v[6+i] - v[i];
      end
      c[0] = e1[1]*e2[2] - e1[2]*e2[1];
      c[1] = e1[2]*e2[0] - e1[0]*e2[2];
      c[2] = e1[0]*e2[1] - e1[1]*e2[0];
      s = '0;
      for (int i = 0; i < 3; i++)
         s += 128'($unsigned(c[i] < 0 ? -c[i] : c[i])) * 128'($unsigned(c[i] < 0 ? -c[i] : c[i]));
      m = int_sqrt(s);
      n = '0;
      if (m == 0) begin
         n.degen = 1'b1;
         return n;
      end
      for (int i = 0; i < 3; i++) begin
         q = ((c[i] < 0 ? -c[i] : c[i]) * 16384) / longint'(m);
         if (c[i] < 0) q = -q;
         if (i == 0) n.nx = q[15:0];
         else if (i == 1) n.ny = q[15:0];
         else n.nz = q[15:0];
      end
      return n;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // check each accepted response against the oldest prediction
   always @(posedge clock) begin
      normal_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[48:0];
         if (normal_q.size() == 0) begin
            report_mismatch("unexpected response", 0, 0);
         end else begin
            want = normal_q.pop_front();
            if (got.nx !== want.nx) report_mismatch("normal_x", got.nx, want.nx);
            if (got.ny !== want.ny) report_mismatch("normal_y", got.ny, want.ny);
            if (got.nz !== want.nz) report_mismatch("normal_z", got.nz, want.nz);
            if (got.degen !== want.degen)
               report_mismatch("degenerate", got.degen, want.degen);
         end
      end
   end

   // drive ready; a hold count forces a long stall
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_triangle(logic [143:0] tri_bits);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= tri_bits;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      normal_q = {normal_q, unit_normal(tri_bits)};
   endtask

   function automatic logic [143:0] make_tri(int c[9]);
      logic [143:0] t;
      for (int i = 0; i < 9; i++) t[16*i +: 16] = c[i][15:0];
      return t;
   endfunction

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(4))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($signed($urandom_range(8)) - 4);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      send_triangle(make_tri('{0,0,0, 0,0,0, 0,0,0}));
      send_triangle(make_tri('{1,2,3, 1,2,3, 1,2,3}));
      send_triangle(make_tri('{0,0,0, 1,2,3, 2,4,6}));
      send_triangle(make_tri('{0,0,0, 1,0,0, 0,1,0}));
      send_triangle(make_tri('{0,0,0, 0,1,0, 1,0,0}));
      send_triangle(make_tri('{0,0,0, 0,1,0, 0,0,1}));
      send_triangle(make_tri('{0,0,0, 0,0,1, 1,0,0}));
      send_triangle(make_tri('{5,5,5, 6,6,5, 5,6,6}));
      send_triangle(make_tri('{-32768,-32768,-32768, 32767,-32768,-32768,
                               -32768,32767,-32768}));
      send_triangle(make_tri('{32767,32767,32767, -32768,32767,-32768,
                               32767,-32768,-32768}));
      send_triangle(make_tri('{-32768,32767,-32768, 32767,-32768,32767,
                               -32768,-32768,32767}));
      send_triangle(make_tri('{32767,-32768,0, -32768,32767,0, 0,0,32767}));
      send_triangle({16'hffff, 16'h0000, 16'h7fff, 16'h8000, 16'haaaa,
                     16'h5555, 16'h1234, 16'hfedc, 16'h0001});
      send_triangle({16'h0000, 16'hffff, 16'h8000, 16'h7fff, 16'h5555,
                     16'haaaa, 16'hedcb, 16'h0123, 16'hfffe});
   endtask

   task automatic test_random(int n);
      logic [143:0] t;
      for (int k = 0; k < n; k++) begin
         for (int i = 0; i < 9; i++) t[16*i +: 16] = rand_coord();
         if ($urandom_range(15) == 0) t[143:96] = t[47:0];
         send_triangle(t);
      end
   endtask

   task automatic test_backpressure();
      hold_cycles <= 300;
      send_idle_pct = 0;
      test_random(60);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (normal_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (200) @(posedge clock);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      send_idle_pct = 38; recv_idle_pct = 51;
      test_random(130);
      send_idle_pct = 51; recv_idle_pct = 38;
      test_random(130);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(70);
      test_backpressure();
      drain();
      if (error_count == 0 && normal_q.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (normal_q.size() != 0) report_mismatch("responses missing", normal_q.size(), 0);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== triangle_unit_normal.f =====
rtl/tun_pkg.sv
rtl/tun_sqrt_cell.sv
rtl/tun_div_cell.sv
rtl/triangle_unit_normal.sv
sim/triangle_unit_normal_tb.sv
